/* hw/rtl/sdrd_pkg.sv */
package sdrd_pkg;

   // Parser phase, one-hot
   typedef enum logic [2:0] {
      PH_OP   = 3'b001,
      PH_LEN  = 3'b010,
      PH_DATA = 3'b100
   } phase_type;

   // Record op codes
   localparam logic [7:0] OP_SKIP = 8'h00;
   localparam logic [7:0] OP_DATA = 8'hFF;

   // Fixed field widths
   localparam int OFFSET_W = 16;
   localparam int BYTE_W   = 8;
   localparam int LEN_W    = 64;
   localparam int LEN_IDX_W = 3;

   // One write item on the result side
   typedef struct packed {
      logic [OFFSET_W-1:0] write_offset;
      logic [BYTE_W-1:0]   write_byte;
      logic                beyond_range;
   } result_type;

endpackage

/* hw/rtl/sdrd_out_buf.sv */
module sdrd_out_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   input  sdrd_pkg::result_type in_item,
   output logic                in_stall,
   output logic                out_valid,
   output sdrd_pkg::result_type out_item,
   input  logic                out_stall
);
   import sdrd_pkg::*;

   logic       main_valid_ff, main_valid_in;
   result_type main_item_ff, main_item_in;
   logic       skid_valid_ff, skid_valid_in;
   result_type skid_item_ff, skid_item_in;
   logic       pop;

   // Upstream stalls only while the skid stage holds an item
   assign in_stall  = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_item  = main_item_ff;
   assign pop       = main_valid_ff && !out_stall;

   // Refill the main stage from the skid stage first, else from the input
   always_comb begin
      main_valid_in = main_valid_ff;
      main_item_in  = main_item_ff;
      skid_valid_in = skid_valid_ff;
      skid_item_in  = skid_item_ff;
      if (!main_valid_ff || pop) begin
         if (skid_valid_ff) begin
            main_valid_in = 1'b1;
            main_item_in  = skid_item_ff;
            skid_valid_in = 1'b0;
         end else begin
            main_valid_in = in_valid;
            main_item_in  = in_item;
         end
      end else if (in_valid) begin
         skid_valid_in = 1'b1;
         skid_item_in  = in_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         main_valid_ff <= main_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_item_ff <= main_item_in;
      skid_item_ff <= skid_item_in;
   end

endmodule

/* hw/rtl/state_delta_run_decoder_unit.sv */
// Run-length delta decoder. Takes one delta stream byte per accepted item and
// gives one write item (offset, byte, beyond_range) for each data byte of an
// 0xFF record, registered in the output buffer. A new byte is accepted every
// cycle while input is not stalled: the parser state is updated in a single pass
// of logic per byte, and a two-entry output stage lets input continue while one
// result waits. Input stalls only when both output entries are full. Records are
// an op byte followed by an 8-byte little-endian length; op 0x00 skips the
// position ahead, and ops other than 0xFF end with their length field. req_first
// restarts the parser at position zero. Positions saturate at MAX_STATE_BYTES,
// and writes there come out with beyond_range set and offset zero.
module state_delta_run_decoder_unit #(
   parameter int MAX_STATE_BYTES = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_delta_byte,
   input  logic        req_first,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_write_offset,
   output logic [7:0]  rsp_write_byte,
   output logic        rsp_beyond_range
);
   import sdrd_pkg::*;

   localparam int PW = $clog2(MAX_STATE_BYTES) + 1;
   localparam logic [PW-1:0] MAX_POS = PW'(MAX_STATE_BYTES);

   phase_type             phase_ff, phase_in;
   logic [BYTE_W-1:0]     op_ff, op_in;
   logic [LEN_W-1:0]      count_ff, count_in;
   logic [LEN_IDX_W-1:0]  idx_ff, idx_in;
   logic [PW-1:0]         pos_ff, pos_in;

   logic                  accept;
   phase_type             cur_phase;
   logic [PW-1:0]         cur_pos;
   logic [PW-1:0]         room;
   logic [LEN_W-1:0]      len_full;
   logic                  skip_sat;
   logic                  beyond;
   logic                  res_valid;
   result_type            res_item;
   result_type            out_item;

   assign accept = req_valid && !req_stall;

   // A first byte restarts the parser and the position
   assign cur_phase = req_first ? PH_OP : phase_ff;
   assign cur_pos   = req_first ? '0 : pos_ff;
   assign room      = MAX_POS - cur_pos;
   assign beyond    = (cur_pos >= MAX_POS);

   // Merge the incoming length byte into its little-endian place
   assign len_full = count_ff | ({{(LEN_W-BYTE_W){1'b0}}, req_delta_byte} << {idx_ff, 3'b000});
   assign skip_sat = (|len_full[LEN_W-1:PW]) || (len_full[PW-1:0] >= room);

   // Parser step for one accepted byte
   always_comb begin
      phase_in  = phase_ff;
      op_in     = op_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      res_valid = 1'b0;
      res_item.write_offset = beyond ? '0 : OFFSET_W'(cur_pos);
      res_item.write_byte   = req_delta_byte;
      res_item.beyond_range = beyond;
      if (accept) begin
         pos_in = cur_pos;
         case (cur_phase)
            PH_LEN: begin
               count_in = len_full;
               if (idx_ff == '1) begin
                  idx_in   = '0;
                  phase_in = PH_OP;
                  if (op_ff == OP_SKIP) begin
                     pos_in = skip_sat ? MAX_POS : cur_pos + len_full[PW-1:0];
                  end else if (op_ff == OP_DATA && len_full != '0) begin
                     phase_in = PH_DATA;
                  end
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            PH_DATA: begin
               res_valid = 1'b1;
               pos_in    = beyond ? MAX_POS : cur_pos + 1'b1;
               count_in  = count_ff - 1'b1;
               if (count_ff == {{(LEN_W-1){1'b0}}, 1'b1}) begin
                  phase_in = PH_OP;
               end
            end
            default: begin
               op_in    = req_delta_byte;
               count_in = '0;
               idx_in   = '0;
               phase_in = PH_LEN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_OP;
         op_ff    <= '0;
         count_ff <= '0;
         idx_ff   <= '0;
         pos_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         op_ff    <= op_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         pos_ff   <= pos_in;
      end
   end

   // Hold results until the consumer takes them
   sdrd_out_buf u_out_buf (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_item   (res_item),
      .in_stall  (req_stall),
      .out_valid (rsp_valid),
      .out_item  (out_item),
      .out_stall (rsp_stall)
   );

   assign rsp_write_offset = out_item.write_offset;
   assign rsp_write_byte   = out_item.write_byte;
   assign rsp_beyond_range = out_item.beyond_range;

endmodule

/* hw/rtl/sdrd_checker.sv */
module sdrd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic [7:0]  req_delta_byte,
   input logic        req_first,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_write_offset,
   input logic [7:0]  rsp_write_byte,
   input logic        rsp_beyond_range
);

   // Hold a stalled result item
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_write_offset)
         && $stable(rsp_write_byte) && $stable(rsp_beyond_range))
      else $error("stalled result item changed");

   // Input stalls only while a result is waiting
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // Stall rises only after a result was held back
   assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stall rose without output backpressure");

   // Dropped writes carry a zero offset
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_beyond_range |-> rsp_write_offset == 16'd0)
      else $error("out-of-range write with nonzero offset");

   // Leave reset with no result and no stall
   assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

endmodule

bind state_delta_run_decoder_unit sdrd_checker u_sdrd_checker (.*);
